/* rtl/pgrc_pkg.sv */
// shared types, codes and constants of the proximity gate relay controller
// no dependencies; imported by every module of the block
package pgrc_pkg;

  localparam int unsigned DIST_BITS      = 20;
  localparam int unsigned WEIGHT_W       = 10;
  localparam int unsigned TICK_W         = 20;
  localparam int unsigned CFG_W          = 20;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned PROD_W         = DIST_BITS + WEIGHT_W;
  localparam int unsigned REFLECTORS_DEF = 4;

  localparam int unsigned WEIGHT_FULL = 1000;

  // register reset values
  localparam int unsigned WEIGHT_RST     = 100;
  localparam int unsigned RED_ZONE_RST   = 2000;
  localparam int unsigned OPEN_ZONE_RST  = 40000;
  localparam int unsigned MOVE_THR_RST   = 1000;
  localparam int unsigned PULSE_RST      = 16384;
  localparam int unsigned OPEN_HOLD_RST  = 262144;
  localparam int unsigned CLOSE_HOLD_RST = 327680;

  typedef enum logic [1:0] {
    OP_CONNECT = 2'd0,
    OP_MEASURE = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    Z_JUST   = 2'd0,
    Z_MOVING = 2'd1,
    Z_RED    = 2'd2
  } zone_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT     = 3'd0,
    CFG_RED_ZONE   = 3'd1,
    CFG_OPEN_ZONE  = 3'd2,
    CFG_MOVE_THR   = 3'd3,
    CFG_PULSE      = 3'd4,
    CFG_OPEN_HOLD  = 3'd5,
    CFG_CLOSE_HOLD = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic [1:0]           reflector;
    logic [DIST_BITS-1:0] distance_mm;
  } in_word_t;

  typedef struct packed {
    logic                 open_relay_pin;
    logic                 close_relay_pin;
    logic                 busy_led;
    logic                 gate_open;
    logic [1:0]           reflector_zone;
    logic [DIST_BITS-1:0] smoothed_distance;
    logic [DIST_BITS-1:0] baseline_distance;
    logic [1:0]           relay_phase;
  } out_word_t;

  // relay sequencer status
  typedef struct packed {
    logic       open_pin;
    logic       close_pin;
    logic       led;
    logic [1:0] phase;
    logic       idle;
  } relay_t;

endpackage

/* rtl/pgrc_div1000.sv */
// floor division of the weighted baseline sum by 1000
// shift by three, then reciprocal multiply for 125; uses pgrc_pkg
module pgrc_div1000 (
  input  logic [pgrc_pkg::PROD_W-1:0]    dividend_i,
  output logic [pgrc_pkg::DIST_BITS-1:0] quotient_o
);
  import pgrc_pkg::*;

  localparam int unsigned QW = PROD_W - 3;
  localparam int unsigned K  = QW + 7;
  localparam int unsigned MW = K - 6;
  localparam longint unsigned RECIP = ((64'd1 << K) + 64'd124) / 64'd125;

  logic [QW-1:0]    q8;
  logic [MW-1:0]    recip;
  logic [QW+MW-1:0] prod;

  assign q8         = dividend_i[PROD_W-1:3];
  assign recip      = RECIP[MW-1:0];
  assign prod       = (QW+MW)'(q8) * (QW+MW)'(recip);
  assign quotient_o = prod[K +: DIST_BITS];

endmodule

/* rtl/pgrc_relay.sv */
// low-high-low relay pulse sequencer with led and hold countdown
// uses pgrc_pkg for the status struct and timer width
module pgrc_relay (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        tick_i,
  input  logic                        start_i,
  input  logic                        start_open_i,
  input  logic [pgrc_pkg::TICK_W-1:0] pulse_ticks_i,
  input  logic [pgrc_pkg::TICK_W-1:0] open_hold_ticks_i,
  input  logic [pgrc_pkg::TICK_W-1:0] close_hold_ticks_i,
  output pgrc_pkg::relay_t            cur_o,
  output pgrc_pkg::relay_t            nxt_o
);
  import pgrc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_HOLD = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                dir_q, dir_d;
  logic [TICK_W-1:0]   cnt_q, cnt_d;
  logic                open_q, open_d;
  logic                close_q, close_d;
  logic                led_q, led_d;
  logic                step;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    open_d  = open_q;
    close_d = close_q;
    led_d   = led_q;
    dir_d   = start_i ? start_open_i : dir_q;
    step    = start_i || (tick_i && (phase_q != PH_IDLE) && (cnt_q <= TICK_W'(1)));
    if (step) begin
      case (phase_q)
        PH_IDLE: begin
          led_d   = 1'b1;
          if (dir_d) open_d = 1'b0;
          else close_d = 1'b0;
          phase_d = PH_LOW;
          cnt_d   = pulse_ticks_i;
        end
        PH_LOW: begin
          if (dir_d) open_d = 1'b1;
          else close_d = 1'b1;
          phase_d = PH_HIGH;
          cnt_d   = pulse_ticks_i;
        end
        PH_HIGH: begin
          if (dir_d) open_d = 1'b0;
          else close_d = 1'b0;
          phase_d = PH_HOLD;
          cnt_d   = dir_d ? open_hold_ticks_i : close_hold_ticks_i;
        end
        default: begin
          led_d   = 1'b0;
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end
      endcase
    end else if (tick_i && (phase_q != PH_IDLE)) begin
      cnt_d = cnt_q - TICK_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dir_q   <= 1'b0;
      cnt_q   <= '0;
      open_q  <= 1'b0;
      close_q <= 1'b0;
      led_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      dir_q   <= dir_d;
      cnt_q   <= cnt_d;
      open_q  <= open_d;
      close_q <= close_d;
      led_q   <= led_d;
    end
  end

  assign cur_o.open_pin  = open_q;
  assign cur_o.close_pin = close_q;
  assign cur_o.led       = led_q;
  assign cur_o.phase     = phase_q;
  assign cur_o.idle      = (phase_q == PH_IDLE);

  assign nxt_o.open_pin  = open_d;
  assign nxt_o.close_pin = close_d;
  assign nxt_o.led       = led_d;
  assign nxt_o.phase     = phase_d;
  assign nxt_o.idle      = (phase_d == PH_IDLE);

`ifndef SYNTH
  a_led_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    led_q == (phase_q != PH_IDLE))
    else $error("relay led does not follow sequence activity");

  a_pin_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q || close_q) |-> (!(open_q && close_q) && (phase_q == PH_HIGH)))
    else $error("relay pin high outside the high step");

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (cnt_q == '0))
    else $error("relay countdown left running while idle");
`endif

endmodule

/* rtl/proximity_gate_relay_controller_top.sv */
// proximity gate relay controller: reflector tracking, gate requests, relay drive
// uses pgrc_pkg, pgrc_div1000 and pgrc_relay
//
// usage
// - input channel (in_valid_i / in_ready_o / in_i) carries one word per connect,
//   distance measurement or 32768 Hz timer tick
// - output channel (out_valid_o / out_ready_i / out_o) returns one word per input
//   word, in order, with pin, led, gate, zone, distance and phase levels as they
//   stand after that word has been applied
// - registers are written on the plain port (cfg_we_i, cfg_index_i, cfg_data_i),
//   by the user only while the block is idle; the block does not enforce this
// - path: an accepted word passes the weighted sum register, then the result
//   register, before it shows on out_valid_o
// - throughput: one word per cycle while the receiver takes results; a measurement
//   directly behind a measurement of the same reflector waits until that one leaves
//   stage two, since its baseline comes out of the divide by 1000 there
// - receiver stall: the result register holds, the second stage keeps its word
//   and the input channel drops ready until the result is taken
// - reset: zones just connected, gate closed, relay idle, pins and led low,
//   registers at their defaults; distance stores are undefined until measured
module proximity_gate_relay_controller_top #(
  parameter int unsigned REFLECTORS = pgrc_pkg::REFLECTORS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pgrc_pkg::in_word_t             in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pgrc_pkg::out_word_t            out_o,
  input  logic                           cfg_we_i,
  input  logic [pgrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pgrc_pkg::CFG_W-1:0]     cfg_data_i
);
  import pgrc_pkg::*;

  localparam int unsigned IDX_W = (REFLECTORS > 1) ? $clog2(REFLECTORS) : 1;

  // configuration registers
  logic [WEIGHT_W-1:0]  weight_q;
  logic [DIST_BITS-1:0] red_q, opening_q, thr_q;
  logic [TICK_W-1:0]    pulse_q, ohold_q, chold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q  <= WEIGHT_W'(WEIGHT_RST);
      red_q     <= DIST_BITS'(RED_ZONE_RST);
      opening_q <= DIST_BITS'(OPEN_ZONE_RST);
      thr_q     <= DIST_BITS'(MOVE_THR_RST);
      pulse_q   <= TICK_W'(PULSE_RST);
      ohold_q   <= TICK_W'(OPEN_HOLD_RST);
      chold_q   <= TICK_W'(CLOSE_HOLD_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WEIGHT:     weight_q  <= cfg_data_i[WEIGHT_W-1:0];
        CFG_RED_ZONE:   red_q     <= cfg_data_i[DIST_BITS-1:0];
        CFG_OPEN_ZONE:  opening_q <= cfg_data_i[DIST_BITS-1:0];
        CFG_MOVE_THR:   thr_q     <= cfg_data_i[DIST_BITS-1:0];
        CFG_PULSE:      pulse_q   <= cfg_data_i[TICK_W-1:0];
        CFG_OPEN_HOLD:  ohold_q   <= cfg_data_i[TICK_W-1:0];
        CFG_CLOSE_HOLD: chold_q   <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // per reflector state
  logic [1:0]           zone_q [REFLECTORS];
  logic [DIST_BITS-1:0] base_q [REFLECTORS];
  logic [DIST_BITS-1:0] avg_q  [REFLECTORS];
  logic                 gate_q;

  // second stage registers
  logic                 b_valid_q;
  logic [1:0]           b_op_q;
  logic                 b_ok_q;
  logic [IDX_W-1:0]     b_idx_q;
  logic [DIST_BITS-1:0] b_sample_q, b_base_q, b_avg_q;
  logic [PROD_W-1:0]    b_prod_q;

  // result register
  logic      out_valid_q;
  out_word_t out_q;

  // stage one: reflector lookup and weighted sum
  logic [IDX_W-1:0]     a_idx;
  logic                 a_ok;
  logic                 fwd;
  logic [DIST_BITS-1:0] a_base, a_avg;
  logic [WEIGHT_W-1:0]  w_eff, w_inv;
  logic [PROD_W-1:0]    a_prod;
  logic                 hazard;
  logic                 b_adv, b_fire, in_fire;

  // stage two signals
  logic                 b_meas, b_conn, b_tick;
  logic [1:0]           zone_cur, zone_nxt;
  logic                 first;
  logic [DIST_BITS-1:0] base_div, avg_new, base_wr, avg_wr;
  logic [DIST_BITS:0]   avg_sum;
  logic                 in_red, retreat, approach;
  logic                 any_red;
  logic                 req, want_open, grant, gate_nxt;
  relay_t               relay_cur, relay_nxt;
  out_word_t            res;

  assign a_idx = IDX_W'(in_i.reflector);
  assign a_ok  = 32'(in_i.reflector) < REFLECTORS;

  // new values of the word leaving stage two bypass the stores
  assign fwd    = b_fire && b_meas && (b_idx_q == a_idx);
  assign a_base = fwd ? base_wr : base_q[a_idx];
  assign a_avg  = fwd ? avg_wr : avg_q[a_idx];

  // weights above full scale clamp to full scale
  assign w_eff  = (weight_q > WEIGHT_W'(WEIGHT_FULL)) ? WEIGHT_W'(WEIGHT_FULL) : weight_q;
  assign w_inv  = WEIGHT_W'(WEIGHT_FULL) - w_eff;
  // stored baseline only: a same reflector measurement in stage two stalls this one
  assign a_prod = PROD_W'(in_i.distance_mm) * PROD_W'(w_eff)
                + PROD_W'(base_q[a_idx]) * PROD_W'(w_inv);

  assign hazard = b_valid_q && b_meas && a_ok && (in_i.operation == OP_MEASURE)
                && (b_idx_q == a_idx);

  assign b_adv      = !out_valid_q || out_ready_i;
  assign b_fire     = b_valid_q && b_adv;
  assign in_ready_o = (!b_valid_q || b_adv) && !hazard;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_fire) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_op_q     <= in_i.operation;
      b_ok_q     <= a_ok;
      b_idx_q    <= a_idx;
      b_sample_q <= in_i.distance_mm;
      b_base_q   <= a_base;
      b_avg_q    <= a_avg;
      b_prod_q   <= a_prod;
    end
  end

  // stage two: baseline divide, zone update, gate request
  pgrc_div1000 u_div (
    .dividend_i (b_prod_q),
    .quotient_o (base_div)
  );

  assign b_meas = (b_op_q == OP_MEASURE) && b_ok_q;
  assign b_conn = (b_op_q == OP_CONNECT) && b_ok_q;
  assign b_tick = (b_op_q == OP_TICK);

  assign zone_cur = zone_q[b_idx_q];
  assign first    = (zone_cur == Z_JUST);
  assign avg_sum  = {1'b0, b_sample_q} + {1'b0, b_avg_q};
  assign avg_new  = avg_sum[DIST_BITS:1];
  assign base_wr  = first ? b_sample_q : base_div;
  assign avg_wr   = first ? b_sample_q : avg_new;

  assign in_red   = (avg_new <= red_q);
  assign retreat  = {1'b0, avg_new} >= ({1'b0, base_div} + {1'b0, thr_q});
  assign approach = ({1'b0, avg_new} + {1'b0, thr_q}) < {1'b0, base_div};

  always_comb begin
    any_red = 1'b0;
    for (int i = 0; i < REFLECTORS; i++) begin
      any_red = any_red || (zone_q[i] == Z_RED);
    end
  end

  always_comb begin
    zone_nxt = zone_cur;
    if (b_conn) begin
      zone_nxt = Z_JUST;
    end else if (b_meas) begin
      case (zone_cur)
        Z_JUST:   zone_nxt = Z_MOVING;
        Z_MOVING: zone_nxt = in_red ? Z_RED : Z_MOVING;
        Z_RED:    zone_nxt = in_red ? Z_RED : Z_MOVING;
        default:  zone_nxt = zone_cur;
      endcase
    end
  end

  // approach only asks to open when no retreat was seen
  assign req       = b_meas && (zone_cur == Z_MOVING) && !in_red && (retreat || approach);
  assign want_open = !retreat;
  assign grant     = req && (gate_q != want_open) && relay_cur.idle && !any_red
                   && (!want_open || (avg_new <= opening_q));
  assign gate_nxt  = grant ? want_open : gate_q;

  pgrc_relay u_relay (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (b_fire),
    .tick_i             (b_tick),
    .start_i            (grant),
    .start_open_i       (want_open),
    .pulse_ticks_i      (pulse_q),
    .open_hold_ticks_i  (ohold_q),
    .close_hold_ticks_i (chold_q),
    .cur_o              (relay_cur),
    .nxt_o              (relay_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= 1'b0;
      for (int i = 0; i < REFLECTORS; i++) begin
        zone_q[i] <= Z_JUST;
      end
    end else if (b_fire) begin
      gate_q <= gate_nxt;
      if (b_conn || b_meas) begin
        zone_q[b_idx_q] <= zone_nxt;
      end
    end
  end

  // distance stores carry no reset
  always_ff @(posedge clk_i) begin
    if (b_fire && b_meas) begin
      base_q[b_idx_q] <= base_wr;
      avg_q[b_idx_q]  <= avg_wr;
    end
  end

  // result word, reflector fields zero for an index out of range
  always_comb begin
    res.open_relay_pin    = relay_nxt.open_pin;
    res.close_relay_pin   = relay_nxt.close_pin;
    res.busy_led          = relay_nxt.led;
    res.gate_open         = gate_nxt;
    res.reflector_zone    = b_ok_q ? zone_nxt : 2'(Z_JUST);
    res.smoothed_distance = '0;
    res.baseline_distance = '0;
    if (b_meas) begin
      res.smoothed_distance = avg_wr;
      res.baseline_distance = base_wr;
    end else if (b_ok_q) begin
      res.smoothed_distance = b_avg_q;
      res.baseline_distance = b_base_q;
    end
    res.relay_phase       = relay_nxt.phase;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_gate_starts_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gate_q != $past(gate_q)) |-> !relay_cur.idle)
    else $error("gate position changed without a relay sequence");

  a_no_back_to_back_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_meas) |=>
      !(b_valid_q && b_meas && (b_idx_q == $past(b_idx_q))))
    else $error("measurement of one reflector followed its own predecessor in stage two");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("result word changed or dropped while waiting");
`endif

endmodule

/* bench/pgrc_checker.sv */
// scoreboard for the proximity gate relay controller: follows reflectors, gate and relay
// sequencer from the accepted input words and register writes, then checks each status word
// depends on pgrc_pkg; instantiated beside the block by the testbench top
module pgrc_checker
  import pgrc_pkg::*;
#(
  parameter int unsigned REFLECTORS = REFLECTORS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_word_t             in_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_word_t            out_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned          mismatches_o,
  output int unsigned          words_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    RELAY_IDLE = 2'd0,
    RELAY_LOW  = 2'd1,
    RELAY_HIGH = 2'd2,
    RELAY_HOLD = 2'd3
  } relay_phase_e;

  // register copies
  logic [WEIGHT_W-1:0]  weight_r;
  logic [DIST_BITS-1:0] red_r, open_zone_r, thr_r;
  logic [TICK_W-1:0]    pulse_r, open_hold_r, close_hold_r;

  // tracked state
  zone_e                zone_q     [REFLECTORS];
  logic [DIST_BITS-1:0] baseline_q [REFLECTORS];
  logic [DIST_BITS-1:0] average_q  [REFLECTORS];
  logic                 gate_q, dir_open_q, open_pin_q, close_pin_q, led_q;
  relay_phase_e         phase_q;
  logic [TICK_W-1:0]    count_q;

  out_word_t status_words_due [$];

  task automatic drive_pin(input logic level);
    if (dir_open_q) open_pin_q = level;
    else            close_pin_q = level;
  endtask

  task automatic relay_advance();
    case (phase_q)
      RELAY_IDLE: begin
        led_q = 1'b1;
        drive_pin(1'b0);
        phase_q = RELAY_LOW;
        count_q = pulse_r;
      end
      RELAY_LOW: begin
        drive_pin(1'b1);
        phase_q = RELAY_HIGH;
        count_q = pulse_r;
      end
      RELAY_HIGH: begin
        drive_pin(1'b0);
        phase_q = RELAY_HOLD;
        count_q = dir_open_q ? open_hold_r : close_hold_r;
      end
      default: begin
        led_q = 1'b0;
        phase_q = RELAY_IDLE;
        count_q = '0;
      end
    endcase
  endtask

  // granted only from the other gate position, with the relay idle and nobody red
  task automatic ask_gate(input logic want_open, input longint unsigned avg);
    if (gate_q == want_open || phase_q != RELAY_IDLE) return;
    if (want_open && avg > open_zone_r) return;
    for (int i = 0; i < REFLECTORS; i++) if (zone_q[i] == Z_RED) return;
    gate_q = want_open;
    dir_open_q = want_open;
    relay_advance();
  endtask

  task automatic check_field(input string name, input logic [DIST_BITS-1:0] want,
                             input logic [DIST_BITS-1:0] seen);
    if (seen !== want) begin
      mismatches_o++;
      $display("%0d ns: %s expected %0d, got %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    in_word_t        word;
    out_word_t       want;
    int unsigned     r;
    logic            known;
    longint unsigned w, sample, base, blended, avg;
    if (!rst_ni) begin
      weight_r     = WEIGHT_W'(WEIGHT_RST);
      red_r        = DIST_BITS'(RED_ZONE_RST);
      open_zone_r  = DIST_BITS'(OPEN_ZONE_RST);
      thr_r        = DIST_BITS'(MOVE_THR_RST);
      pulse_r      = TICK_W'(PULSE_RST);
      open_hold_r  = TICK_W'(OPEN_HOLD_RST);
      close_hold_r = TICK_W'(CLOSE_HOLD_RST);
      for (int i = 0; i < REFLECTORS; i++) begin
        zone_q[i]     = Z_JUST;
        baseline_q[i] = '0;
        average_q[i]  = '0;
      end
      gate_q      = 1'b0;
      dir_open_q  = 1'b0;
      open_pin_q  = 1'b0;
      close_pin_q = 1'b0;
      led_q       = 1'b0;
      phase_q     = RELAY_IDLE;
      count_q     = '0;
      status_words_due.delete();
      words_due_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_WEIGHT:     weight_r     = cfg_data_i[WEIGHT_W-1:0];
          CFG_RED_ZONE:   red_r        = cfg_data_i[DIST_BITS-1:0];
          CFG_OPEN_ZONE:  open_zone_r  = cfg_data_i[DIST_BITS-1:0];
          CFG_MOVE_THR:   thr_r        = cfg_data_i[DIST_BITS-1:0];
          CFG_PULSE:      pulse_r      = cfg_data_i[TICK_W-1:0];
          CFG_OPEN_HOLD:  open_hold_r  = cfg_data_i[TICK_W-1:0];
          CFG_CLOSE_HOLD: close_hold_r = cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        word  = in_i;
        r     = word.reflector;
        known = r < REFLECTORS;
        if (word.operation == OP_CONNECT && known) begin
          zone_q[r] = Z_JUST;
        end else if (word.operation == OP_MEASURE && known) begin
          if (zone_q[r] == Z_JUST) begin
            // first sample seeds both stores, no gate request
            baseline_q[r] = word.distance_mm;
            average_q[r]  = word.distance_mm;
            zone_q[r]     = Z_MOVING;
          end else begin
            sample  = word.distance_mm;
            w       = (weight_r > WEIGHT_FULL) ? WEIGHT_FULL : weight_r;
            blended = (sample * w + baseline_q[r] * (WEIGHT_FULL - w)) / WEIGHT_FULL;
            baseline_q[r] = blended[DIST_BITS-1:0];
            base = baseline_q[r];
            avg  = (sample + average_q[r]) >> 1;
            average_q[r] = avg[DIST_BITS-1:0];
            if (zone_q[r] == Z_MOVING) begin
              if (avg <= red_r)             zone_q[r] = Z_RED;
              else if (avg >= base + thr_r) ask_gate(1'b0, avg);
              else if (avg + thr_r < base)  ask_gate(1'b1, avg);
            end else if (zone_q[r] == Z_RED && avg > red_r) begin
              zone_q[r] = Z_MOVING;
            end
          end
        end else if (word.operation == OP_TICK && phase_q != RELAY_IDLE) begin
          if (count_q <= 1) begin
            count_q = '0;
            relay_advance();
          end else begin
            count_q = count_q - 1'b1;
          end
        end

        want.open_relay_pin    = open_pin_q;
        want.close_relay_pin   = close_pin_q;
        want.busy_led          = led_q;
        want.gate_open         = gate_q;
        want.reflector_zone    = known ? zone_q[r] : Z_JUST;
        want.smoothed_distance = known ? average_q[r] : '0;
        want.baseline_distance = known ? baseline_q[r] : '0;
        want.relay_phase       = phase_q;
        status_words_due.push_back(want);
      end

      if (out_valid_i && out_ready_i) begin
        if (status_words_due.size() == 0) begin
          mismatches_o++;
          $display("%0d ns: status word expected none, got %h", $time, out_i);
        end else begin
          want = status_words_due.pop_front();
          check_field("open_relay_pin", want.open_relay_pin, out_i.open_relay_pin);
          check_field("close_relay_pin", want.close_relay_pin, out_i.close_relay_pin);
          check_field("busy_led", want.busy_led, out_i.busy_led);
          check_field("gate_open", want.gate_open, out_i.gate_open);
          check_field("reflector_zone", want.reflector_zone, out_i.reflector_zone);
          check_field("smoothed_distance", want.smoothed_distance, out_i.smoothed_distance);
          check_field("baseline_distance", want.baseline_distance, out_i.baseline_distance);
          check_field("relay_phase", want.relay_phase, out_i.relay_phase);
        end
      end
      words_due_o = status_words_due.size();
    end
  end

endmodule

/* bench/tb_proximity_gate_relay_controller_top.sv */
// testbench top for the proximity gate relay controller: clock, reset, input words,
// register settings, receiver back-pressure and the verdict
// depends on pgrc_pkg, the block's rtl and pgrc_checker
module tb_proximity_gate_relay_controller_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pgrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PRESS_AFTER   = 700;     // results taken before the long hold-off
  localparam int unsigned PRESS_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES = 4;       // two-stage latency plus margin
  localparam int unsigned FULL_DIST     = 20'hFFFFF;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int unsigned mismatches, words_due;
  int unsigned cycles          = 0;
  int unsigned words_sent      = 0;
  int unsigned results_taken   = 0;
  int unsigned settings_loaded = 0;
  int unsigned gate_moves      = 0;
  int unsigned tx_steady       = 0;
  logic        last_gate       = 1'b0;

  // per-reflector position and heading for the drifting measurements
  int unsigned spot    [REFLECTORS_DEF];
  logic        closing [REFLECTORS_DEF];

  proximity_gate_relay_controller_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pgrc_checker scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .words_due_o  (words_due)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d words outstanding",
               cycles, words_sent - results_taken);
      $display("TEST FAILED");
      $finish;
    end
  end

  // count taken results and gate movements on the output side
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_taken++;
      if (out_word.gate_open != last_gate) gate_moves++;
      last_gate = out_word.gate_open;
    end
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // receiver: random stalls, steady stretches and one long hold-off so that the
  // block backs up and drops in_ready
  initial begin : result_sink
    int unsigned held, steady;
    logic        pressed;
    held    = 0;
    steady  = 0;
    pressed = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (held != 0) begin
        held--;
        out_ready <= 1'b0;
      end else if (!pressed && results_taken >= PRESS_AFTER) begin
        pressed = 1'b1;
        held = PRESS_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (steady != 0) steady--;
        else if ($urandom_range(0, 99) < 4) steady = $urandom_range(50, 200);
        if (steady == 0 && $urandom_range(0, 99) < 25) begin
          held = idle_length() - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // offer one word, starting and ending on a falling edge; valid stays high
  // across back-to-back words
  task automatic push_word(input logic [1:0] op, input int unsigned r, input int unsigned d);
    int unsigned gap;
    in_word_t    w;
    if (tx_steady != 0) begin
      tx_steady--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) tx_steady = $urandom_range(30, 150);
      gap = ($urandom_range(0, 99) < 30) ? idle_length() : 0;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    w.operation   = op;
    w.reflector   = r[1:0];
    w.distance_mm = d[DIST_BITS-1:0];
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_setting(input cfg_idx_e idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(negedge clk);
  endtask

  task automatic load_settings(input int unsigned weight, input int unsigned red,
                               input int unsigned open_zone, input int unsigned thr,
                               input int unsigned pulse, input int unsigned open_hold,
                               input int unsigned close_hold);
    write_setting(CFG_WEIGHT, weight);
    write_setting(CFG_RED_ZONE, red);
    write_setting(CFG_OPEN_ZONE, open_zone);
    write_setting(CFG_MOVE_THR, thr);
    write_setting(CFG_PULSE, pulse);
    write_setting(CFG_OPEN_HOLD, open_hold);
    write_setting(CFG_CLOSE_HOLD, close_hold);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // drain the block before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    while (results_taken != words_sent) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly drifting measurements and ticks so that approaches, retreats, red
  // zone entries and full relay sequences occur; the rest is noise
  task automatic random_part(input int unsigned count, input int unsigned span);
    int unsigned pick, r, step, d;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, REFLECTORS_DEF - 1);
      d    = $urandom_range(0, FULL_DIST);
      if (pick < 40) begin
        push_word(OP_TICK, r, d);
      end else if (pick < 85) begin
        step = $urandom_range(span / 100, span / 10);
        if (spot[r] > span) spot[r] = span;
        if ($urandom_range(0, 5) == 0) closing[r] = !closing[r];
        if (closing[r]) begin
          if (spot[r] > step) spot[r] -= step;
          else begin
            spot[r] = 0;
            closing[r] = 1'b0;
          end
        end else begin
          if (span - spot[r] > step) spot[r] += step;
          else begin
            spot[r] = span;
            closing[r] = 1'b1;
          end
        end
        push_word(OP_MEASURE, r, spot[r]);
      end else if (pick < 90) begin
        push_word(OP_CONNECT, r, d);
      end else if (pick < 95) begin
        push_word(OP_UNUSED, r, d);
      end else begin
        push_word(OP_MEASURE, r, d);
      end
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < REFLECTORS_DEF; i++) begin
      spot[i]    = 30000;
      closing[i] = 1'b1;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words at the reset settings; every reflector is measured before
    // any word addresses it, and reflector 3 sits in the red zone while the
    // approach cases run so that no slow relay sequence starts here
    push_word(OP_MEASURE, 3, 500);         // first sample seeds both stores
    push_word(OP_MEASURE, 3, 500);         // average below red threshold: red zone
    push_word(OP_MEASURE, 0, FULL_DIST);   // largest distance
    push_word(OP_MEASURE, 1, 0);           // smallest distance
    push_word(OP_MEASURE, 2, 20000);
    push_word(OP_MEASURE, 0, 0);           // sharp approach, refused while red
    push_word(OP_MEASURE, 1, FULL_DIST);   // retreat with the gate already closed
    push_word(OP_TICK, 0, 0);              // tick with the relay idle
    push_word(OP_UNUSED, 1, 20'hABCDE);    // unused operation
    push_word(OP_CONNECT, 2, FULL_DIST);   // reconnect drops back to just connected
    push_word(OP_MEASURE, 2, 30000);       // first sample again after reconnect
    push_word(OP_MEASURE, 2, 10000);       // approach inside the opening zone, still red
    push_word(OP_MEASURE, 3, 3000);        // stays red
    push_word(OP_MEASURE, 3, 6000);        // leaves the red zone
    push_word(OP_TICK, 3, FULL_DIST);
    push_word(OP_UNUSED, 0, 0);

    // quick relay timing so that complete sequences fit the run
    settle();
    load_settings(100, 2000, 40000, 1000, 2, 5, 7);
    random_part(300, 60000);

    // weight above full scale, zero tick counts, no threshold, opening anywhere
    settle();
    load_settings(1023, 0, FULL_DIST, 0, 0, 0, 0);
    random_part(300, FULL_DIST);

    // everything counts as red, zero opening zone, largest threshold
    settle();
    load_settings(0, FULL_DIST, 0, FULL_DIST, 1, 1, 1);
    random_part(150, FULL_DIST);

    repeat (3) begin
      settle();
      load_settings($urandom_range(0, 1023), $urandom_range(0, 4000),
                    $urandom_range(0, 80000), $urandom_range(0, 4000),
                    $urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 12));
      random_part(320, 60000);
    end

    // longest relay timing last, since a started sequence stays busy for good
    settle();
    load_settings(1000, 1500, 45000, 800, FULL_DIST, FULL_DIST, FULL_DIST);
    random_part(250, 60000);

    in_valid <= 1'b0;
    while (results_taken != words_sent) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d words under %0d register settings, gate moved %0d times",
             words_sent, settings_loaded, gate_moves);
    $display("output side held off for %0d cycles once to back up the input side",
             PRESS_CYCLES);
    if (words_due != 0) $display("%0d status words never arrived", words_due);
    if (mismatches == 0 && words_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
